>>> rtl/cse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cse_pkg
// Shared types and character codes for the C string escape encoder.
// ----------------------------------------------------------------------------
package cse_pkg;

	localparam int unsigned RUN_MAX   = 4;
	localparam int unsigned RUN_IDX_W = $clog2(RUN_MAX);

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_EIGHT  = 8'h38;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] PRINT_LO  = 8'h20;
	localparam logic [7:0] PRINT_HI  = 8'h7E;
	localparam logic [7:0] OCT_HIGH  = 8'd64;
	localparam logic [7:0] OCT_MID   = 8'd8;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       new_string;
	} raw_beat_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} esc_beat_t;

	// escaped run of one input byte, chars[0] goes out first
	typedef struct packed {
		logic [RUN_MAX-1:0][7:0] chars;
		logic [RUN_IDX_W-1:0]    last_idx;
	} run_t;

endpackage

>>> rtl/c_string_escape_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_string_escape_encoder
// Escapes raw bytes for a C string literal, one output byte per beat.
// ----------------------------------------------------------------------------
//  channel  | signals                  | beat
//  ---------+--------------------------+--------------------------------
//  raw      | raw_valid, raw_stall, raw | one input byte, new_string mark
//  esc      | esc_valid, esc_stall, esc | one escaped char, last_of_run
//
//  each input byte becomes 1 to 4 escaped characters; the output
//  register sends one character a cycle unless esc_stall is high and
//  sets the rate. An accepted byte goes to beat_s1, then run_s2.
//  arst_n clears valids and the octal-escape flag.
//  esc_stall holds the current character; the input register takes the
//  next byte while the last character of a run is still waiting, if empty.
// ----------------------------------------------------------------------------
module c_string_escape_encoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                raw_valid,
	output logic                raw_stall,
	input  cse_pkg::raw_beat_t  raw,
	output logic                esc_valid,
	input  logic                esc_stall,
	output cse_pkg::esc_beat_t  esc
);

	logic                              valid_s1;
	cse_pkg::raw_beat_t                beat_s1;
	logic                              valid_s2;
	cse_pkg::run_t                     run_s2;
	logic [cse_pkg::RUN_IDX_W-1:0]     idx_q;
	logic                              after_octal_q;

	cse_pkg::run_t                     run_next;
	logic                              after_octal_next;
	logic                              last_char;
	logic                              run_done;
	logic                              load_s2;
	logic                              load_s1;

	cse_encode u_encode (
		.beat             (beat_s1),
		.after_octal      (after_octal_q),
		.run              (run_next),
		.next_after_octal (after_octal_next)
	);

	assign last_char = (idx_q == run_s2.last_idx);
	assign run_done  = valid_s2 & ~esc_stall & last_char;
	assign load_s2   = valid_s1 & (~valid_s2 | run_done);
	assign raw_stall = valid_s1 & ~load_s2;
	assign load_s1   = raw_valid & ~raw_stall;

	assign esc_valid       = valid_s2;
	assign esc.out_byte    = run_s2.chars[idx_q];
	assign esc.last_of_run = last_char;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			idx_q         <= '0;
			after_octal_q <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= 1'b1;
			end else if (load_s2) begin
				valid_s1 <= 1'b0;
			end
			if (load_s2) begin
				valid_s2      <= 1'b1;
				idx_q         <= '0;
				after_octal_q <= after_octal_next;
			end else if (run_done) begin
				valid_s2 <= 1'b0;
				idx_q    <= '0;
			end else if (valid_s2 && !esc_stall) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (load_s1) begin
			beat_s1 <= raw;
		end
		if (load_s2) begin
			run_s2 <= run_next;
		end
	end

endmodule

>>> rtl/cse_encode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cse_encode
// Maps one raw byte and the octal-escape flag to its escaped character run.
// ----------------------------------------------------------------------------
module cse_encode (
	input  cse_pkg::raw_beat_t beat,
	input  logic               after_octal,
	output cse_pkg::run_t      run,
	output logic               next_after_octal
);

	logic [7:0] c;
	logic       flag_eff;
	logic [7:0] d_hi;
	logic [7:0] d_mid;
	logic [7:0] d_lo;

	assign c        = beat.in_byte;
	assign flag_eff = after_octal & ~beat.new_string;
	assign d_hi     = cse_pkg::CH_ZERO + {6'd0, c[7:6]};
	assign d_mid    = cse_pkg::CH_ZERO + {5'd0, c[5:3]};
	assign d_lo     = cse_pkg::CH_ZERO + {5'd0, c[2:0]};

	always_comb begin
		run              = '0;
		next_after_octal = 1'b0;
		if (flag_eff && c >= cse_pkg::CH_ZERO && c < cse_pkg::CH_EIGHT) begin
			// close and reopen the literal so the digit does not extend the escape
			run.chars[0] = cse_pkg::CH_DQUOTE;
			run.chars[1] = cse_pkg::CH_DQUOTE;
			run.chars[2] = c;
			run.last_idx = 2'd2;
		end else if (c == cse_pkg::CH_BSLASH || c == cse_pkg::CH_DQUOTE) begin
			run.chars[0] = cse_pkg::CH_BSLASH;
			run.chars[1] = c;
			run.last_idx = 2'd1;
		end else if (c >= cse_pkg::PRINT_LO && c <= cse_pkg::PRINT_HI) begin
			run.chars[0] = c;
			run.last_idx = 2'd0;
		end else if (c == cse_pkg::CH_LF) begin
			run.chars[0] = cse_pkg::CH_BSLASH;
			run.chars[1] = cse_pkg::CH_N;
			run.last_idx = 2'd1;
		end else if (c == cse_pkg::CH_CR) begin
			run.chars[0] = cse_pkg::CH_BSLASH;
			run.chars[1] = cse_pkg::CH_R;
			run.last_idx = 2'd1;
		end else if (c == cse_pkg::CH_TAB) begin
			run.chars[0] = cse_pkg::CH_BSLASH;
			run.chars[1] = cse_pkg::CH_T;
			run.last_idx = 2'd1;
		end else begin
			next_after_octal = 1'b1;
			run.chars[0]     = cse_pkg::CH_BSLASH;
			if (c >= cse_pkg::OCT_HIGH) begin
				run.chars[1] = d_hi;
				run.chars[2] = d_mid;
				run.chars[3] = d_lo;
				run.last_idx = 2'd3;
			end else if (c >= cse_pkg::OCT_MID) begin
				run.chars[1] = d_mid;
				run.chars[2] = d_lo;
				run.last_idx = 2'd2;
			end else begin
				run.chars[1] = d_lo;
				run.last_idx = 2'd1;
			end
		end
	end

endmodule
